[sv/tmtw_pkg.sv]
package tmtw_pkg;

   // screen geometry
   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = ROWS * COLUMNS;

   // widths of the port fields
   localparam int OP_W    = 3;
   localparam int BYTE_W  = 8;
   localparam int ROW_W   = 5;
   localparam int COL_W   = 7;

   // internal index widths
   localparam int ROW_IDX_W = $clog2(ROWS);
   localparam int COL_IDX_W = $clog2(COLUMNS);
   localparam int ADDR_W    = $clog2(CELL_COUNT);
   localparam int CNT_W     = $clog2(CELL_COUNT + 1);

   localparam logic [BYTE_W-1:0] BLANK_CHAR  = 8'h20;
   localparam logic [BYTE_W-1:0] RESET_COLOR = 8'h07;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUT_CHAR     = 3'd0;
   localparam logic [OP_W-1:0] OP_WRITE_CELL   = 3'd1;
   localparam logic [OP_W-1:0] OP_CLEAR_ROW    = 3'd2;
   localparam logic [OP_W-1:0] OP_CLEAR_SCREEN = 3'd3;
   localparam logic [OP_W-1:0] OP_READ_CELL    = 3'd4;

   typedef struct packed {
      logic [BYTE_W-1:0] color;
      logic [BYTE_W-1:0] chr;
   } cell_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      cell_type          data;
   } ram_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } ram_rd_type;

   // logical row to physical row, rows rotate by the scroll base
   function automatic logic [ROW_IDX_W-1:0] phys_row(input logic [ROW_IDX_W-1:0] row,
                                                     input logic [ROW_IDX_W-1:0] base);
      logic [ROW_IDX_W:0] sum;
      sum = {1'b0, row} + {1'b0, base};
      if (sum >= (ROW_IDX_W+1)'(ROWS)) begin
         sum = sum - (ROW_IDX_W+1)'(ROWS);
      end
      return sum[ROW_IDX_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_IDX_W-1:0] row,
                                                   input logic [COL_IDX_W-1:0] col);
      return ADDR_W'(row) * ADDR_W'(COLUMNS) + ADDR_W'(col);
   endfunction

endpackage

[sv/tmtw_screen_ram.sv]
module tmtw_screen_ram (
   input  logic                clock,
   input  tmtw_pkg::ram_wr_type wr,
   input  tmtw_pkg::ram_rd_type rd,
   output tmtw_pkg::cell_type   rd_data
);
   import tmtw_pkg::*;

   cell_type mem [CELL_COUNT];
   cell_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/tmtw_ctrl.sv]
module tmtw_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [tmtw_pkg::OP_W-1:0]   op,
   input  logic [tmtw_pkg::BYTE_W-1:0] char_code,
   input  logic [tmtw_pkg::BYTE_W-1:0] color_in,
   input  logic [tmtw_pkg::ROW_W-1:0]  row_sel,
   input  logic [tmtw_pkg::COL_W-1:0]  col_sel,
   input  logic [tmtw_pkg::BYTE_W-1:0] text_color,
   output tmtw_pkg::ram_wr_type        wr,
   output tmtw_pkg::ram_rd_type        rd,
   input  tmtw_pkg::cell_type          rd_data,
   output logic                        rsp_valid,
   output logic [tmtw_pkg::BYTE_W-1:0] rsp_char,
   output logic [tmtw_pkg::BYTE_W-1:0] rsp_color,
   output logic [tmtw_pkg::ROW_W-1:0]  rsp_row,
   output logic [tmtw_pkg::COL_W-1:0]  rsp_col
);
   import tmtw_pkg::*;

   typedef enum logic [2:0] {S_INIT, S_IDLE, S_EXEC, S_FILL, S_READ} state_type;

   state_type             state_ff, state_in;
   logic [OP_W-1:0]       op_ff, op_in;
   logic [BYTE_W-1:0]     char_ff, char_in;
   logic [BYTE_W-1:0]     attr_ff, attr_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_IDX_W-1:0]  cursor_row_ff, cursor_row_in;
   logic [COL_IDX_W-1:0]  cursor_col_ff, cursor_col_in;
   logic [ROW_IDX_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0]     fill_addr_ff, fill_addr_in;
   logic [CNT_W-1:0]      fill_cnt_ff, fill_cnt_in;
   cell_type              fill_data_ff, fill_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]     rsp_char_ff, rsp_char_in;
   logic [BYTE_W-1:0]     rsp_color_ff, rsp_color_in;

   logic [ROW_IDX_W-1:0]  cur_phys;
   logic [ROW_IDX_W-1:0]  sel_phys;
   logic                  row_ok;
   logic                  in_range;

   assign cur_phys = phys_row(cursor_row_ff, base_ff);
   assign sel_phys = phys_row(ROW_IDX_W'(row_ff), base_ff);
   assign row_ok   = 32'(row_ff) < 32'(ROWS);
   assign in_range = row_ok && (32'(col_ff) < 32'(COLUMNS));

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      char_in       = char_ff;
      attr_in       = attr_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      cursor_row_in = cursor_row_ff;
      cursor_col_in = cursor_col_ff;
      base_in       = base_ff;
      fill_addr_in  = fill_addr_ff;
      fill_cnt_in   = fill_cnt_ff;
      fill_data_in  = fill_data_ff;
      rsp_valid_in  = 1'b0;
      rsp_char_in   = rsp_char_ff;
      rsp_color_in  = rsp_color_ff;
      wr            = '0;
      rd            = '0;

      unique case (state_ff)
         S_INIT, S_FILL: begin
            wr.en        = 1'b1;
            wr.addr      = fill_addr_ff;
            wr.data      = fill_data_ff;
            fill_addr_in = fill_addr_ff + ADDR_W'(1);
            fill_cnt_in  = fill_cnt_ff - CNT_W'(1);
            if (fill_cnt_ff == CNT_W'(1)) begin
               state_in = S_IDLE;
               if (state_ff == S_FILL) begin
                  rsp_valid_in = 1'b1;
                  rsp_char_in  = '0;
                  rsp_color_in = '0;
               end
            end
         end
         S_IDLE: begin
            if (start) begin
               op_in    = op;
               char_in  = char_code;
               attr_in  = color_in;
               row_in   = row_sel;
               col_in   = col_sel;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            rsp_char_in  = '0;
            rsp_color_in = '0;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            unique case (op_ff)
               OP_PUT_CHAR: begin
                  wr.en   = 1'b1;
                  wr.addr = cell_addr(cur_phys, cursor_col_ff);
                  wr.data = '{color: text_color, chr: char_ff};
                  if (cursor_col_ff == COL_IDX_W'(COLUMNS - 1)) begin
                     cursor_col_in = '0;
                     if (cursor_row_ff == ROW_IDX_W'(ROWS - 1)) begin
                        // scroll: rotate base, old top row becomes the new bottom row
                        base_in      = (base_ff == ROW_IDX_W'(ROWS - 1)) ? '0
                                       : base_ff + ROW_IDX_W'(1);
                        fill_addr_in = cell_addr(base_ff, '0);
                        fill_cnt_in  = CNT_W'(COLUMNS);
                        fill_data_in = '0;
                        rsp_valid_in = 1'b0;
                        state_in     = S_FILL;
                     end else begin
                        cursor_row_in = cursor_row_ff + ROW_IDX_W'(1);
                     end
                  end else begin
                     cursor_col_in = cursor_col_ff + COL_IDX_W'(1);
                  end
               end
               OP_WRITE_CELL: begin
                  wr.en   = in_range;
                  wr.addr = cell_addr(sel_phys, COL_IDX_W'(col_ff));
                  wr.data = '{color: attr_ff, chr: char_ff};
               end
               OP_CLEAR_ROW: begin
                  if (row_ok) begin
                     fill_addr_in = cell_addr(sel_phys, '0);
                     fill_cnt_in  = CNT_W'(COLUMNS);
                     fill_data_in = '{color: text_color, chr: BLANK_CHAR};
                     rsp_valid_in = 1'b0;
                     state_in     = S_FILL;
                  end
               end
               OP_CLEAR_SCREEN: begin
                  fill_addr_in  = '0;
                  fill_cnt_in   = CNT_W'(CELL_COUNT);
                  fill_data_in  = '{color: text_color, chr: BLANK_CHAR};
                  cursor_row_in = '0;
                  cursor_col_in = '0;
                  rsp_valid_in  = 1'b0;
                  state_in      = S_FILL;
               end
               OP_READ_CELL: begin
                  if (in_range) begin
                     rd.en        = 1'b1;
                     rd.addr      = cell_addr(sel_phys, COL_IDX_W'(col_ff));
                     rsp_valid_in = 1'b0;
                     state_in     = S_READ;
                  end
               end
               default: begin
               end
            endcase
         end
         S_READ: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = rd_data.chr;
            rsp_color_in = rd_data.color;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_INIT;
         cursor_row_ff <= '0;
         cursor_col_ff <= '0;
         base_ff       <= '0;
         fill_addr_ff  <= '0;
         fill_cnt_ff   <= CNT_W'(CELL_COUNT);
         fill_data_ff  <= '{color: RESET_COLOR, chr: BLANK_CHAR};
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cursor_row_ff <= cursor_row_in;
         cursor_col_ff <= cursor_col_in;
         base_ff       <= base_in;
         fill_addr_ff  <= fill_addr_in;
         fill_cnt_ff   <= fill_cnt_in;
         fill_data_ff  <= fill_data_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      op_ff        <= op_in;
      char_ff      <= char_in;
      attr_ff      <= attr_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_char  = rsp_char_ff;
   assign rsp_color = rsp_color_ff;
   assign rsp_row   = ROW_W'(cursor_row_ff);
   assign rsp_col   = COL_W'(cursor_col_ff);

endmodule

[sv/text_mode_terminal_writer_top.sv]
// text screen writer: a screen of character/attribute cells plus a cursor
// command channel: an item transfers on a rising edge with start high and busy low
//    (req_op, req_char_code, req_cell_color_in, req_row_sel, req_col_sel)
// result channel: rsp_valid marks one transfer, held for exactly one cycle, with
//    the read cell (zero unless a read in range) and the cursor after the item
// csr port: csr_we writes csr_wdata into the current text colour at once
// states each item passes through from its accepting edge back to idle; the strobe
// is raised in the same cycle that busy falls:
//    put char, write cell, unused codes, out-of-range read or row clear: exec
//    read cell in range: exec, read (registered read of the screen memory)
//    clear row and put char with scroll: exec, fill of COLUMNS cells, one a cycle
//    clear screen: exec, fill of CELL_COUNT cells
// scrolling rotates a row base instead of moving cells, so only the new
// bottom row is written
// after reset the block sweeps the screen memory to blanks, one cell a cycle,
// over all CELL_COUNT (2000) cells with busy high; csr writes are still taken then
// the receiver has no way to stall, so every strobe is a completed transfer
module text_mode_terminal_writer_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [tmtw_pkg::OP_W-1:0]   req_op,
   input  logic [tmtw_pkg::BYTE_W-1:0] req_char_code,
   input  logic [tmtw_pkg::BYTE_W-1:0] req_cell_color_in,
   input  logic [tmtw_pkg::ROW_W-1:0]  req_row_sel,
   input  logic [tmtw_pkg::COL_W-1:0]  req_col_sel,
   output logic                        rsp_valid,
   output logic [tmtw_pkg::BYTE_W-1:0] rsp_cell_char,
   output logic [tmtw_pkg::BYTE_W-1:0] rsp_cell_color,
   output logic [tmtw_pkg::ROW_W-1:0]  rsp_cursor_row_out,
   output logic [tmtw_pkg::COL_W-1:0]  rsp_cursor_col_out,
   input  logic                        csr_we,
   input  logic [tmtw_pkg::BYTE_W-1:0] csr_wdata
);
   import tmtw_pkg::*;

   // current text colour register
   logic [BYTE_W-1:0] text_color_ff;

   // screen memory ports
   ram_wr_type ram_wr;
   ram_rd_type ram_rd;
   cell_type   ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         text_color_ff <= RESET_COLOR;
      end else if (csr_we) begin
         text_color_ff <= csr_wdata;
      end
   end

   // sequencer: decodes items, runs fills and scrolls, builds the result
   tmtw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .op         (req_op),
      .char_code  (req_char_code),
      .color_in   (req_cell_color_in),
      .row_sel    (req_row_sel),
      .col_sel    (req_col_sel),
      .text_color (text_color_ff),
      .wr         (ram_wr),
      .rd         (ram_rd),
      .rd_data    (ram_rd_data),
      .rsp_valid  (rsp_valid),
      .rsp_char   (rsp_cell_char),
      .rsp_color  (rsp_cell_color),
      .rsp_row    (rsp_cursor_row_out),
      .rsp_col    (rsp_cursor_col_out)
   );

   // one write port, one registered read port
   tmtw_screen_ram u_screen_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_rd_data)
   );

endmodule

[bench/tb.sv]
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tmtw_pkg::*;

   // op codes the block leaves unused: nothing changes, cursor is echoed
   localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
   localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

   // quiet cycles allowed before the run is called hung; the slowest gaps are the
   // sweep after reset and a clear screen
   localparam int IDLE_LIMIT = 20000;

   localparam int PHASE_ITEMS [3] = '{2040, 80, 60};
   localparam int PHASE_IDLE  [3] = '{32, 62, 0};
   localparam int PHASE_PUTS  [3] = '{99, 95, 50};

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] chr;
      logic [BYTE_W-1:0] color;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } command_type;

   typedef struct packed {
      logic [BYTE_W-1:0] chr;
      logic [BYTE_W-1:0] color;
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  col;
   } answer_type;

   typedef struct packed {
      command_type cmd;
      logic        typed;   // answer below is taken as it stands
      answer_type  want;
   } script_line_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [OP_W-1:0]     req_op = '0;
   logic [BYTE_W-1:0]   req_char_code = '0;
   logic [BYTE_W-1:0]   req_cell_color_in = '0;
   logic [ROW_W-1:0]    req_row_sel = '0;
   logic [COL_W-1:0]    req_col_sel = '0;
   logic                rsp_valid;
   logic [BYTE_W-1:0]   rsp_cell_char;
   logic [BYTE_W-1:0]   rsp_cell_color;
   logic [ROW_W-1:0]    rsp_cursor_row_out;
   logic [COL_W-1:0]    rsp_cursor_col_out;
   logic                csr_we = 1'b0;
   logic [BYTE_W-1:0]   csr_wdata = '0;

   // shadow of the screen, the cursor and the text colour
   cell_type            screen [CELL_COUNT];
   int                  cur_row;
   int                  cur_col;
   logic [BYTE_W-1:0]   pen_color;

   answer_type          answers_due [$];
   int                  failures = 0;
   int                  quiet_cycles = 0;
   int                  sender_idle_pct = 0;

   // directed opening: reads of two corners and of each out-of-range edge, both
   // put-char extremes, writes in and out of range, the spare op codes, row clears
   // in and out of range (cursor must not move) and a clear screen with home
   script_line_type directed_script [24] = '{
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd0,  7'd0  }, 1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd24, 7'd79 }, 1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}},
      '{'{OP_READ_CELL,    8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd24, 7'd80 }, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd25, 7'd0  }, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{'{OP_PUT_CHAR,     8'hFF, 8'h00, 5'd31, 7'd127}, 1'b0, '0},
      '{'{OP_PUT_CHAR,     8'h00, 8'hFF, 5'd0,  7'd0  }, 1'b0, '0},
      '{'{OP_WRITE_CELL,   8'hA5, 8'h5A, 5'd24, 7'd79 }, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
      '{'{OP_WRITE_CELL,   8'h11, 8'h22, 5'd25, 7'd0  }, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
      '{'{OP_WRITE_CELL,   8'h33, 8'h44, 5'd0,  7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd24, 7'd79 }, 1'b1, '{8'hA5, 8'h5A, 5'd0, 7'd2}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd0,  7'd1  }, 1'b1, '{8'h00, 8'h07, 5'd0, 7'd2}},
      '{'{OP_SPARE_5,      8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
      '{'{OP_SPARE_6,      8'h00, 8'h00, 5'd0,  7'd0  }, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
      '{'{OP_SPARE_7,      8'h5A, 8'hA5, 5'd3,  7'd9  }, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
      '{'{OP_CLEAR_ROW,    8'h00, 8'h00, 5'd24, 7'd0  }, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd24, 7'd79 }, 1'b1, '{8'h20, 8'h07, 5'd0, 7'd2}},
      '{'{OP_CLEAR_ROW,    8'h00, 8'h00, 5'd31, 7'd0  }, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd2}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd0,  7'd0  }, 1'b1, '{8'hFF, 8'h07, 5'd0, 7'd2}},
      '{'{OP_WRITE_CELL,   8'h00, 8'hFF, 5'd0,  7'd0  }, 1'b0, '0},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd0,  7'd0  }, 1'b0, '0},
      '{'{OP_CLEAR_SCREEN, 8'hFF, 8'hFF, 5'd31, 7'd127}, 1'b1, '{8'h00, 8'h00, 5'd0, 7'd0}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd0,  7'd0  }, 1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}},
      '{'{OP_READ_CELL,    8'h00, 8'h00, 5'd0,  7'd1  }, 1'b1, '{8'h20, 8'h07, 5'd0, 7'd0}}
   };

   text_mode_terminal_writer_top DUT (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_op             (req_op),
      .req_char_code      (req_char_code),
      .req_cell_color_in  (req_cell_color_in),
      .req_row_sel        (req_row_sel),
      .req_col_sel        (req_col_sel),
      .rsp_valid          (rsp_valid),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_color     (rsp_cell_color),
      .rsp_cursor_row_out (rsp_cursor_row_out),
      .rsp_cursor_col_out (rsp_cursor_col_out),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata)
   );

   always #6 clock = ~clock;

   // shadow terminal: applies one command and returns the answer it must give
   function automatic answer_type apply_command(input command_type c);
      answer_type a;
      bit         on_screen;
      a = '0;
      on_screen = (c.row < ROWS) && (c.col < COLUMNS);
      case (c.op)
         OP_PUT_CHAR: begin
            screen[cur_row * COLUMNS + cur_col] = cell_type'{color: pen_color, chr: c.chr};
            cur_col++;
            if (cur_col >= COLUMNS) begin
               cur_col = 0;
               cur_row++;
               // past the bottom: shift up one line, new bottom row is all zero
               if (cur_row >= ROWS) begin
                  for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen[i] = screen[i + COLUMNS];
                  for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen[i] = '0;
                  cur_row = ROWS - 1;
               end
            end
         end
         OP_WRITE_CELL: begin
            if (on_screen) screen[c.row * COLUMNS + c.col] = cell_type'{color: c.color, chr: c.chr};
         end
         OP_CLEAR_ROW: begin
            if (c.row < ROWS) begin
               for (int i = 0; i < COLUMNS; i++)
                  screen[c.row * COLUMNS + i] = cell_type'{color: pen_color, chr: BLANK_CHAR};
            end
         end
         OP_CLEAR_SCREEN: begin
            for (int i = 0; i < CELL_COUNT; i++)
               screen[i] = cell_type'{color: pen_color, chr: BLANK_CHAR};
            cur_row = 0;
            cur_col = 0;
         end
         OP_READ_CELL: begin
            if (on_screen) begin
               a.chr   = screen[c.row * COLUMNS + c.col].chr;
               a.color = screen[c.row * COLUMNS + c.col].color;
            end
         end
         default: ;
      endcase
      a.row = ROW_W'(cur_row);
      a.col = COL_W'(cur_col);
      return a;
   endfunction

   // mostly in-range positions, now and then anything the port width allows;
   // without homing, put-char runs build up to scrolls
   function automatic command_type random_command(input int put_share, input bit allow_home);
      command_type c;
      int          pick;
      c.chr   = BYTE_W'($urandom_range(0, 255));
      c.color = BYTE_W'($urandom_range(0, 255));
      c.row   = ($urandom_range(0, 4) == 0) ? ROW_W'($urandom_range(0, 31))
                                            : ROW_W'($urandom_range(0, ROWS - 1));
      c.col   = ($urandom_range(0, 4) == 0) ? COL_W'($urandom_range(0, 127))
                                            : COL_W'($urandom_range(0, COLUMNS - 1));
      if ($urandom_range(0, 99) < put_share) begin
         c.op = OP_PUT_CHAR;
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 40)      c.op = OP_READ_CELL;
         else if (pick < 70) c.op = OP_WRITE_CELL;
         else if (pick < 85) c.op = OP_CLEAR_ROW;
         else if (pick < 92) c.op = OP_W'($urandom_range(OP_SPARE_5, OP_SPARE_7));
         else                c.op = allow_home ? OP_CLEAR_SCREEN : OP_READ_CELL;
      end
      return c;
   endfunction

   // present one command from a falling edge, with random idle cycles first,
   // and hold it until the block takes the transfer
   task automatic issue_command(input command_type c, input logic typed, input answer_type want);
      answer_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start             <= 1'b1;
      req_op            <= c.op;
      req_char_code     <= c.chr;
      req_cell_color_in <= c.color;
      req_row_sel       <= c.row;
      req_col_sel       <= c.col;
      do @(posedge clock); while (busy);
      predicted = apply_command(c);
      answers_due.push_back(typed ? want : predicted);
   endtask

   // stop sending and wait until every answer is back
   task automatic drain_answers();
      @(negedge clock);
      start <= 1'b0;
      while (answers_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // the colour register only changes while nothing is in flight
   task automatic load_text_color(input logic [BYTE_W-1:0] value);
      drain_answers();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      pen_color = value;
   endtask

   // result side: every strobe is a transfer, matched against the oldest answer due
   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            $error("result transfer with no command outstanding");
            failures++;
         end else begin
            due = answers_due.pop_front();
            if (rsp_cell_char !== due.chr) begin
               $error("cell_char: expected %0h, got %0h", due.chr, rsp_cell_char);
               failures++;
            end
            if (rsp_cell_color !== due.color) begin
               $error("cell_color: expected %0h, got %0h", due.color, rsp_cell_color);
               failures++;
            end
            if (rsp_cursor_row_out !== due.row) begin
               $error("cursor_row_out: expected %0d, got %0d", due.row, rsp_cursor_row_out);
               failures++;
            end
            if (rsp_cursor_col_out !== due.col) begin
               $error("cursor_col_out: expected %0d, got %0d", due.col, rsp_cursor_col_out);
               failures++;
            end
         end
      end
   end

   // hang detection: cycles with neither a command nor a result transfer
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   initial begin
      int phase;
      int n;
      for (int i = 0; i < CELL_COUNT; i++)
         screen[i] = cell_type'{color: RESET_COLOR, chr: BLANK_CHAR};
      cur_row   = 0;
      cur_col   = 0;
      pen_color = RESET_COLOR;

      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // colour written at its reset value first, so the directed answers hold
      load_text_color(RESET_COLOR);
      foreach (directed_script[i])
         issue_command(directed_script[i].cmd, directed_script[i].typed, directed_script[i].want);

      // phase 0 is nearly all put-char, enough to fill the screen and scroll;
      // phase 1 scrolls again under a new colour; phase 2 adds homing
      for (phase = 0; phase < 3; phase++) begin
         case (phase)
            0:       load_text_color(8'hFF);
            1:       load_text_color(8'h00);
            default: load_text_color(BYTE_W'($urandom_range(0, 255)));
         endcase
         sender_idle_pct = PHASE_IDLE[phase];
         for (n = 0; n < PHASE_ITEMS[phase]; n++) begin
            // every so often the sender stops until all answers are in
            if (n != 0 && n % 250 == 0) load_text_color(BYTE_W'($urandom_range(0, 255)));
            issue_command(random_command(PHASE_PUTS[phase], phase == 2), 1'b0, '0);
         end
      end

      drain_answers();
      repeat (10) @(negedge clock);
      if (failures == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

[files.f]
sv/tmtw_pkg.sv
sv/tmtw_screen_ram.sv
sv/tmtw_ctrl.sv
sv/text_mode_terminal_writer_top.sv
bench/tb.sv
